// File: hw/rtl/thp_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers for the sensor compensation core
package thp_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_TEMP_CAL    = 3'd0;
    localparam logic [2:0] CFG_PRESS_CAL_A = 3'd1;
    localparam logic [2:0] CFG_PRESS_CAL_B = 3'd2;
    localparam logic [2:0] CFG_PRESS_CAL_C = 3'd3;
    localparam logic [2:0] CFG_HUM_CAL     = 3'd4;

    // pipeline geometry
    localparam int DIV_STEPS = 64;                    // one quotient bit per stage
    localparam int TH_LAT    = 10;                    // temperature / humidity result stage
    localparam int OUT_LAT   = DIV_STEPS + 20;        // output register stage
    localparam int HUM_DLY   = OUT_LAT - TH_LAT;      // alignment delay for temp / humidity

    typedef struct packed {
        logic [47:0] temp_cal;
        logic [47:0] press_cal_a;
        logic [47:0] press_cal_b;
        logic [47:0] press_cal_c;
        logic [63:0] hum_cal;
    } thp_cal_t;

    // fine temperature and raw pressure handed from the temperature path to the pressure path
    typedef struct packed {
        logic               valid;
        logic signed [31:0] t_fine;
        logic [19:0]        adc_p;
    } thp_tf_t;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

endpackage

// File: hw/rtl/thp_mul64.sv
`timescale 1ns / 1ps
// two-stage 64 x 64 multiplier, product modulo 2^64, built from 32 x 32 partials
module thp_mul64 (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] prod
);
    logic [63:0] ll_reg;
    logic [31:0] hl_reg;
    logic [31:0] lh_reg;
    logic [63:0] prod_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            ll_reg   <= a[31:0] * b[31:0];
            hl_reg   <= a[63:32] * b[31:0];
            lh_reg   <= a[31:0] * b[63:32];
            prod_reg <= ll_reg + {hl_reg + lh_reg, 32'b0};
        end
    end

    assign prod = prod_reg;
endmodule

// File: hw/rtl/thp_div.sv
`timescale 1ns / 1ps
// pipelined signed 64-bit divider, restoring, one quotient bit per stage
module thp_div (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] num_abs,
    input  logic [63:0] den_abs,
    input  logic        neg,
    input  logic        fault_in,
    output logic [63:0] quot,
    output logic        fault_out
);
    import thp_pkg::*;

    logic [63:0] rem_reg [DIV_STEPS];
    logic [63:0] nq_reg  [DIV_STEPS];
    logic [63:0] dv_reg  [DIV_STEPS];
    logic        neg_reg [DIV_STEPS];
    logic        flt_reg [DIV_STEPS];
    logic [63:0] quot_reg;
    logic        fault_reg;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [63:0] rem_in;
        logic [63:0] nq_in;
        logic [63:0] dv_in;
        logic        neg_in;
        logic        flt_in;
        logic [64:0] cand;
        logic [64:0] diff;
        logic        ge;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = num_abs;
            assign dv_in  = den_abs;
            assign neg_in = neg;
            assign flt_in = fault_in;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign nq_in  = nq_reg[k-1];
            assign dv_in  = dv_reg[k-1];
            assign neg_in = neg_reg[k-1];
            assign flt_in = flt_reg[k-1];
        end

        assign cand = {rem_in, nq_in[63]};
        assign diff = cand - {1'b0, dv_in};
        assign ge   = ~diff[64];

        always_ff @(posedge clk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[63:0] : cand[63:0];
                nq_reg[k]  <= {nq_in[62:0], ge};
                dv_reg[k]  <= dv_in;
                neg_reg[k] <= neg_in;
                flt_reg[k] <= flt_in;
            end
        end
    end

    // sign fix, wraps naturally for the most negative dividend
    always_ff @(posedge clk) begin
        if (en) begin
            quot_reg  <= neg_reg[DIV_STEPS-1] ? (64'd0 - nq_reg[DIV_STEPS-1])
                                              : nq_reg[DIV_STEPS-1];
            fault_reg <= flt_reg[DIV_STEPS-1];
        end
    end

    assign quot      = quot_reg;
    assign fault_out = fault_reg;
endmodule

// File: hw/rtl/thp_th.sv
`timescale 1ns / 1ps
// temperature and humidity compensation pipeline, 32-bit wrapping arithmetic
module thp_th (
    input  logic              clk,
    input  logic              rstn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [19:0]       raw_temp,
    input  logic [19:0]       raw_press,
    input  logic [15:0]       raw_hum,
    input  thp_pkg::thp_cal_t cal,
    output thp_pkg::thp_tf_t  tf,
    output logic [23:0]       temp_centideg,
    output logic [13:0]       hum_centipct
);
    import thp_pkg::*;

    localparam logic signed [31:0] TEMP_RND   = 32'sd128;
    localparam logic signed [31:0] TEMP_MAX   = 32'sd8388607;
    localparam logic signed [31:0] TEMP_MIN   = -32'sd8388608;
    localparam logic signed [31:0] HUM_TF_OFS = 32'sd76800;
    localparam logic signed [31:0] HUM_X_RND  = 32'sd16384;
    localparam logic signed [31:0] HUM_Y0_OFS = 32'sd32768;
    localparam logic signed [31:0] HUM_Y1_OFS = 32'sd2097152;
    localparam logic signed [31:0] HUM_Y_RND  = 32'sd8192;
    localparam logic signed [31:0] HUM_MAX    = 32'sd419430400;
    localparam logic [23:0]        HUM_SCALE  = 24'd100;

    // coefficients
    logic signed [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
    assign t1 = {16'b0, cal.temp_cal[15:0]};
    assign t2 = {{16{cal.temp_cal[31]}}, cal.temp_cal[31:16]};
    assign t3 = {{16{cal.temp_cal[47]}}, cal.temp_cal[47:32]};
    assign h1 = {24'b0, cal.hum_cal[7:0]};
    assign h2 = {{16{cal.hum_cal[23]}}, cal.hum_cal[23:8]};
    assign h3 = {24'b0, cal.hum_cal[31:24]};
    assign h4 = {{20{cal.hum_cal[43]}}, cal.hum_cal[43:32]};
    assign h5 = {{20{cal.hum_cal[55]}}, cal.hum_cal[55:44]};
    assign h6 = {{24{cal.hum_cal[63]}}, cal.hum_cal[63:56]};

    logic [2:0] vld_reg;

    logic signed [31:0] pa1_reg, pdd1_reg, a2_reg, m3_2_reg, tf3_reg;
    logic signed [31:0] mh5_4_reg, mh3_4_reg, mh6_4_reg;
    logic signed [31:0] x5_reg, zy5_reg, x6_reg, m2_6_reg, v7_reg;
    logic signed [31:0] xx8_reg, v8_reg, th9_reg, v9_reg;
    logic [15:0]        hraw_reg [1:4];
    logic [19:0]        praw_reg [1:3];
    logic [23:0]        temp_reg [4:10];
    logic [13:0]        hum10_reg;

    // combinational pieces per stage
    logic signed [31:0] ta, dt, v4, tm, tv, xs, y0, y1, y7, x8, v10;
    logic [23:0]        temp_sat;
    logic [28:0]        hcl;
    logic [23:0]        hprod;

    assign ta = $signed({15'b0, raw_temp[19:3]}) - (t1 <<< 1);
    assign dt = $signed({16'b0, raw_temp[19:4]}) - t1;

    assign tm = (tf3_reg <<< 2) + tf3_reg + TEMP_RND;
    assign tv = tm >>> 8;
    assign v4 = tf3_reg - HUM_TF_OFS;

    always_comb begin
        if (tv > TEMP_MAX) begin
            temp_sat = TEMP_MAX[23:0];
        end else if (tv < TEMP_MIN) begin
            temp_sat = TEMP_MIN[23:0];
        end else begin
            temp_sat = tv[23:0];
        end
    end

    assign xs  = $signed({2'b0, hraw_reg[4], 14'b0}) - (h4 <<< 20) - mh5_4_reg + HUM_X_RND;
    assign y0  = (mh3_4_reg >>> 11) + HUM_Y0_OFS;
    assign y1  = (zy5_reg >>> 10) + HUM_Y1_OFS;
    assign y7  = (m2_6_reg + HUM_Y_RND) >>> 14;
    assign x8  = v7_reg >>> 15;
    assign v10 = v9_reg - (th9_reg >>> 4);

    // clamp the x4194304 value, drop to x1024, scale to hundredths
    always_comb begin
        if (v10 < 0) begin
            hcl = '0;
        end else if (v10 > HUM_MAX) begin
            hcl = HUM_MAX[28:0];
        end else begin
            hcl = v10[28:0];
        end
    end
    assign hprod = {7'b0, hcl[28:12]} * HUM_SCALE;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            // stage 1
            pa1_reg     <= ta * t2;
            pdd1_reg    <= dt * dt;
            hraw_reg[1] <= raw_hum;
            praw_reg[1] <= raw_press;
            // stage 2
            a2_reg      <= pa1_reg >>> 11;
            m3_2_reg    <= (pdd1_reg >>> 12) * t3;
            // stage 3, fine temperature
            tf3_reg     <= a2_reg + (m3_2_reg >>> 14);
            for (int i = 2; i <= 4; i++) begin
                hraw_reg[i] <= hraw_reg[i-1];
            end
            for (int i = 2; i <= 3; i++) begin
                praw_reg[i] <= praw_reg[i-1];
            end
            // stage 4
            temp_reg[4] <= temp_sat;
            mh5_4_reg   <= h5 * v4;
            mh3_4_reg   <= v4 * h3;
            mh6_4_reg   <= v4 * h6;
            // stage 5
            x5_reg      <= xs >>> 15;
            zy5_reg     <= (mh6_4_reg >>> 10) * y0;
            // stage 6
            x6_reg      <= x5_reg;
            m2_6_reg    <= y1 * h2;
            // stage 7
            v7_reg      <= x6_reg * y7;
            // stage 8
            xx8_reg     <= x8 * x8;
            v8_reg      <= v7_reg;
            // stage 9
            th9_reg     <= (xx8_reg >>> 7) * h1;
            v9_reg      <= v8_reg;
            // stage 10
            hum10_reg   <= hprod[23:10];
            for (int i = 5; i <= 10; i++) begin
                temp_reg[i] <= temp_reg[i-1];
            end
        end
    end

    assign tf.valid      = vld_reg[2];
    assign tf.t_fine     = tf3_reg;
    assign tf.adc_p      = praw_reg[3];
    assign temp_centideg = temp_reg[10];
    assign hum_centipct  = hum10_reg;
endmodule

// File: hw/rtl/thp_press.sv
`timescale 1ns / 1ps
// pressure compensation pipeline, 64-bit wrapping arithmetic with a pipelined divider
module thp_press (
    input  logic              clk,
    input  logic              rstn,
    input  logic              en,
    input  thp_pkg::thp_tf_t  tf,
    input  thp_pkg::thp_cal_t cal,
    output logic              out_valid,
    output logic [23:0]       press_pascal,
    output logic              out_fault
);
    import thp_pkg::*;

    localparam int          PRESS_STAGES = DIV_STEPS + 17;   // stages 4 .. output
    localparam logic [63:0] TF_OFS       = 64'd128000;
    localparam logic [20:0] PN_BASE      = 21'd1048576;
    localparam logic [63:0] NUM_SCALE    = 64'd3125;
    localparam logic [63:0] W_OFS        = 64'h0000_8000_0000_0000;

    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign p1 = {48'b0, cal.press_cal_a[15:0]};
    assign p2 = sx16(cal.press_cal_a[31:16]);
    assign p3 = sx16(cal.press_cal_a[47:32]);
    assign p4 = sx16(cal.press_cal_b[15:0]);
    assign p5 = sx16(cal.press_cal_b[31:16]);
    assign p6 = sx16(cal.press_cal_b[47:32]);
    assign p7 = sx16(cal.press_cal_c[15:0]);
    assign p8 = sx16(cal.press_cal_c[31:16]);
    assign p9 = sx16(cal.press_cal_c[47:32]);

    logic [PRESS_STAGES-1:0] vld_reg;

    logic [63:0] e4_reg;
    logic [19:0] padc_reg [4:8];
    logic [63:0] sq6, ep5_6, ep2_6, sq6p8, sq3p8;
    logic [63:0] ep5_reg [7:8];
    logic [63:0] ep2_reg [7:8];
    logic [63:0] nq9_reg, w9_reg, num11, wp11;
    logic [63:0] num12_reg, den12_reg;
    logic [63:0] na13_reg, da13_reg;
    logic        neg13_reg, fault13_reg;
    logic [63:0] quot78;
    logic        fault78;
    logic [63:0] m9_80, q8_80, m2_82;
    logic [63:0] q_reg  [79:82];
    logic [63:0] q8_reg [81:82];
    logic        flt_reg [79:83];
    logic [39:0] sum83_reg;
    logic [23:0] press84_reg;
    logic        fault84_reg;

    logic [20:0] pn;
    logic [63:0] s9_78, s9_80, sq3_asr, wp_asr, m2_asr, q8_asr;
    logic [31:0] psum;

    assign pn      = PN_BASE - {1'b0, padc_reg[8]};
    assign sq3_asr = $signed(sq3p8) >>> 8;
    assign wp_asr  = $signed(wp11) >>> 33;
    assign s9_78   = $signed(quot78) >>> 13;
    assign s9_80   = $signed(q_reg[80]) >>> 13;
    assign m2_asr  = $signed(m2_82) >>> 25;
    assign q8_asr  = $signed(q8_reg[82]) >>> 19;
    assign psum    = sum83_reg[39:8] + {p7[27:0], 4'b0};

    // offset powers of the fine temperature
    thp_mul64 u_sq  (.clk(clk), .en(en), .a(e4_reg), .b(e4_reg), .prod(sq6));
    thp_mul64 u_ep5 (.clk(clk), .en(en), .a(e4_reg), .b(p5),     .prod(ep5_6));
    thp_mul64 u_ep2 (.clk(clk), .en(en), .a(e4_reg), .b(p2),     .prod(ep2_6));
    thp_mul64 u_sq6 (.clk(clk), .en(en), .a(sq6),    .b(p6),     .prod(sq6p8));
    thp_mul64 u_sq3 (.clk(clk), .en(en), .a(sq6),    .b(p3),     .prod(sq3p8));
    // dividend and divisor
    thp_mul64 u_num (.clk(clk), .en(en), .a(nq9_reg), .b(NUM_SCALE), .prod(num11));
    thp_mul64 u_den (.clk(clk), .en(en), .a(w9_reg),  .b(p1),        .prod(wp11));

    thp_div u_div (
        .clk       (clk),
        .en        (en),
        .num_abs   (na13_reg),
        .den_abs   (da13_reg),
        .neg       (neg13_reg),
        .fault_in  (fault13_reg),
        .quot      (quot78),
        .fault_out (fault78)
    );

    // second-order correction terms
    thp_mul64 u_m9 (.clk(clk), .en(en), .a(p9),    .b(s9_78),  .prod(m9_80));
    thp_mul64 u_q8 (.clk(clk), .en(en), .a(p8),    .b(quot78), .prod(q8_80));
    thp_mul64 u_m2 (.clk(clk), .en(en), .a(m9_80), .b(s9_80),  .prod(m2_82));

    always_ff @(posedge clk) begin
        if (!rstn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PRESS_STAGES-2:0], tf.valid};
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            e4_reg      <= {{32{tf.t_fine[31]}}, tf.t_fine} - TF_OFS;
            padc_reg[4] <= tf.adc_p;
            for (int i = 5; i <= 8; i++) begin
                padc_reg[i] <= padc_reg[i-1];
            end
            ep5_reg[7] <= ep5_6;
            ep5_reg[8] <= ep5_reg[7];
            ep2_reg[7] <= ep2_6;
            ep2_reg[8] <= ep2_reg[7];
            // stage 9
            nq9_reg <= {12'b0, pn, 31'b0} - sq6p8 - (ep5_reg[8] << 17) - (p4 << 35);
            w9_reg  <= sq3_asr + (ep2_reg[8] << 12) + W_OFS;
            // stage 12
            num12_reg <= num11;
            den12_reg <= wp_asr;
            // stage 13, magnitudes for the divider
            na13_reg    <= num12_reg[63] ? (64'd0 - num12_reg) : num12_reg;
            da13_reg    <= den12_reg[63] ? (64'd0 - den12_reg) : den12_reg;
            neg13_reg   <= num12_reg[63] ^ den12_reg[63];
            fault13_reg <= (den12_reg == 64'd0);
            // after the divider
            q_reg[79] <= quot78;
            flt_reg[79] <= fault78;
            for (int i = 80; i <= 82; i++) begin
                q_reg[i] <= q_reg[i-1];
            end
            for (int i = 80; i <= 83; i++) begin
                flt_reg[i] <= flt_reg[i-1];
            end
            q8_reg[81] <= q8_80;
            q8_reg[82] <= q8_reg[81];
            sum83_reg  <= q_reg[82][39:0] + m2_asr[39:0] + q8_asr[39:0];
            press84_reg <= flt_reg[83] ? 24'd0 : psum[31:8];
            fault84_reg <= flt_reg[83];
        end
    end

    assign out_valid    = vld_reg[PRESS_STAGES-1];
    assign press_pascal = press84_reg;
    assign out_fault    = fault84_reg;
endmodule

// File: hw/rtl/thp_sensor_compensation_core.sv
`timescale 1ns / 1ps
// top level of the temperature, humidity and pressure compensation core
//
// usage:
//   s_ side takes one raw sample triple per transaction; m_ side returns one
//   compensated result per transaction, in order. the cfg_ channel writes the
//   calibration words (index 0 temp_cal, 1..3 press_cal_a..c, 4 hum_cal);
//   higher indexes are ignored. cfg_ready is always high; write only while idle.
// throughput: one transaction per cycle while not stalled; the pipeline has no
//   loops. the deepest part is the 64-stage divider for the pressure quotient,
//   one quotient bit per stage.
// stall: the whole pipeline holds when the result register is full and
//   m_tready is low; s_tready drops in that case, nothing is lost.
// reset: aresetn low clears all calibration words and every valid bit;
//   no clearing pass, the core accepts input the cycle after reset.
// fault on m_tuser: pressure divisor was zero, pressure field reads 0.
module thp_sensor_compensation_core (
    input  logic        aclk,
    input  logic        aresetn,
    // raw samples
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,    // raw_temp[19:0], raw_press[39:20], raw_hum[55:40]
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // temp_centideg[23:0], hum_centipct[37:24],
                                    // press_pascal[61:38], zero[63:62]
    output logic        m_tuser,    // fault
    // calibration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import thp_pkg::*;

    thp_cal_t    cal_reg;
    thp_tf_t     tf;
    logic        en;
    logic [23:0] th_temp;
    logic [13:0] th_hum;
    logic [37:0] th_dly_reg [HUM_DLY];
    logic [23:0] press;
    logic        fault;
    logic        press_valid;

    // global advance: the result register is free or being drained
    assign en        = ~m_tvalid | m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // calibration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TEMP_CAL:    cal_reg.temp_cal    <= cfg_data[47:0];
                CFG_PRESS_CAL_A: cal_reg.press_cal_a <= cfg_data[47:0];
                CFG_PRESS_CAL_B: cal_reg.press_cal_b <= cfg_data[47:0];
                CFG_PRESS_CAL_C: cal_reg.press_cal_c <= cfg_data[47:0];
                CFG_HUM_CAL:     cal_reg.hum_cal     <= cfg_data;
                default: ;
            endcase
        end
    end

    // temperature and humidity, also produces the fine temperature
    thp_th u_th (
        .clk           (aclk),
        .rstn          (aresetn),
        .en            (en),
        .in_valid      (s_tvalid),
        .raw_temp      (s_tdata[19:0]),
        .raw_press     (s_tdata[39:20]),
        .raw_hum       (s_tdata[55:40]),
        .cal           (cal_reg),
        .tf            (tf),
        .temp_centideg (th_temp),
        .hum_centipct  (th_hum)
    );

    // pressure path, ends in the output register stage
    thp_press u_press (
        .clk          (aclk),
        .rstn         (aresetn),
        .en           (en),
        .tf           (tf),
        .cal          (cal_reg),
        .out_valid    (press_valid),
        .press_pascal (press),
        .out_fault    (fault)
    );

    // line temperature and humidity up with the pressure result
    always_ff @(posedge aclk) begin
        if (en) begin
            th_dly_reg[0] <= {th_hum, th_temp};
            for (int i = 1; i < HUM_DLY; i++) begin
                th_dly_reg[i] <= th_dly_reg[i-1];
            end
        end
    end

    assign m_tvalid = press_valid;
    assign m_tdata  = {2'b0, press, th_dly_reg[HUM_DLY-1]};
    assign m_tuser  = fault;

    // a faulted result never carries a pressure value
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[61:38] == 24'd0)
        else $error("pressure nonzero on fault");

    // humidity stays within 0..100 percent
    a_hum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[37:24] <= 14'd10000)
        else $error("humidity out of range");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
endmodule
